// ===== rtl/core/double_ended_queue_engine_core_macros.svh =====
// Assertion helpers for the deque engine.
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle check.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque engine check failed");
// Next-cycle check.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque engine check failed");
`else
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int WIDTH_DEF = 32;

	typedef enum logic [3:0] {
		MODE_PUSH_TOP    = 4'd0,
		MODE_PUSH_BOTTOM = 4'd1,
		MODE_POP_TOP     = 4'd2,
		MODE_POP_BOTTOM  = 4'd3,
		MODE_READ_TOP    = 4'd4,
		MODE_READ_BOTTOM = 4'd5,
		MODE_READ_AT     = 4'd6,
		MODE_COUNT       = 4'd7,
		MODE_REVERSE     = 4'd8,
		MODE_CLEAR       = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_RANGE = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_queue_engine_core.sv =====
// Channel   Group  Payload
// request   s_*    tdata: value[31:0], position[39:32]; tuser: mode[3:0]
// result    m_*    tdata: data[31:0], occupancy[40:32], zero pad; tuser: found[0], status[2:1]
//
// One request per cycle unless m_tready back-pressure stalls it; one result per request, in order.
// A result passes through the entry memory's registered read (the read stage) and then
// the result register before m_tvalid rises; the read stage waits while the result
// register is held by m_tready low.
// Pointers, count and direction update at the request transfer, so back-to-back
// requests never collide on the memory.
// Reset clears pointers, count and direction flag; the memory is not cleared.
// s_tready drops only while the result register is held by m_tready low and
// the read stage is also full.
`default_nettype none

`include "double_ended_queue_engine_core_macros.svh"

module double_ended_queue_engine_core
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // value[31:0], position[39:32]
	input  wire logic [3:0]  s_tuser,  // mode[3:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // data[31:0], occupancy[40:32], zeros[47:41]
	output logic [2:0]       m_tuser   // found[0], status[2:1]
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

	// entry memory
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// control state
	logic [AW-1:0] top_q;
	logic [CW-1:0] count_q;
	logic          rev_q;

	// read stage and result register
	logic          s1_valid_q;
	logic          found_s1;
	logic [8:0]    occ_s1;
	status_t       status_s1;
	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic          out_found_q;
	logic [8:0]    out_occ_q;
	status_t       out_status_q;

	logic          in_fire;
	logic          s1_advance;
	mode_t         mode;
	logic [31:0]   value;
	logic [7:0]    position;

	logic          is_full;
	logic          is_empty;
	logic [AW:0]   ring_off;
	logic [AW:0]   fwd_sum;
	logic [AW:0]   fwd_idx;
	logic [AW:0]   back_idx;
	logic [AW-1:0] ring_idx;
	logic [AW-1:0] top_plus;
	logic [AW-1:0] top_minus;
	logic [AW-1:0] top_out;
	logic [AW-1:0] top_in;

	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [WIDTH-1:0] wr_data;
	logic [AW-1:0] top_d;
	logic [CW-1:0] count_d;
	logic          rev_d;
	logic          found_d;
	status_t       status_d;
	logic [CW+8:0] occ_w;
	logic [WIDTH+31:0] val_w;
	logic [WIDTH+31:0] rdata_w;

	assign mode     = mode_t'(s_tuser);
	assign value    = s_tdata[31:0];
	assign position = s_tdata[39:32];

	assign s1_advance = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready   = !s1_valid_q || s1_advance;
	assign in_fire    = s_tvalid && s_tready;

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// distance from the top used by the ring address unit
	always_comb begin
		case (mode)
			MODE_PUSH_BOTTOM: ring_off = (AW + 1)'(count_q);
			MODE_READ_AT:     ring_off = (AW + 1)'(position);
			default:          ring_off = (AW + 1)'(count_q - 1'b1);
		endcase
	end

	assign fwd_sum  = {1'b0, top_q} + ring_off;
	assign fwd_idx  = (fwd_sum >= DEPTH_W) ? fwd_sum - DEPTH_W : fwd_sum;
	assign back_idx = ({1'b0, top_q} >= ring_off) ? {1'b0, top_q} - ring_off
	                                              : {1'b0, top_q} + DEPTH_W - ring_off;
	assign ring_idx = rev_q ? back_idx[AW-1:0] : fwd_idx[AW-1:0];

	assign top_plus  = (top_q == AW'(DEPTH - 1)) ? '0 : top_q + 1'b1;
	assign top_minus = (top_q == '0) ? AW'(DEPTH - 1) : top_q - 1'b1;
	assign top_out   = rev_q ? top_plus : top_minus;
	assign top_in    = rev_q ? top_minus : top_plus;

	assign val_w   = (WIDTH + 32)'(value);
	assign wr_data = val_w[WIDTH-1:0];

	always_comb begin
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = ring_idx;
		rd_addr  = top_q;
		top_d    = top_q;
		count_d  = count_q;
		rev_d    = rev_q;
		found_d  = 1'b0;
		status_d = STATUS_OK;
		case (mode)
			MODE_PUSH_TOP: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = top_out;
					top_d   = top_out;
					count_d = count_q + 1'b1;
				end
			end
			MODE_PUSH_BOTTOM: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP_TOP, MODE_READ_TOP: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					rd_en   = 1'b1;
					found_d = 1'b1;
					if (mode == MODE_POP_TOP) begin
						top_d   = top_in;
						count_d = count_q - 1'b1;
					end
				end
			end
			MODE_POP_BOTTOM, MODE_READ_BOTTOM: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ring_idx;
					found_d = 1'b1;
					if (mode == MODE_POP_BOTTOM) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			MODE_READ_AT: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else if ((CW + 8)'(position) >= (CW + 8)'(count_q)) begin
					status_d = STATUS_RANGE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ring_idx;
					found_d = 1'b1;
				end
			end
			MODE_REVERSE: begin
				// new top is the old bottom
				if (!is_empty) begin
					top_d = ring_idx;
				end
				rev_d = !rev_q;
			end
			MODE_CLEAR: begin
				top_d   = '0;
				count_d = '0;
				rev_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign occ_w   = (CW + 9)'(count_d);
	assign rdata_w = (WIDTH + 32)'(rdata_q);

	always_ff @(posedge clk) begin
		if (in_fire && wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (in_fire && rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				top_q   <= top_d;
				count_q <= count_d;
				rev_q   <= rev_d;
			end
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_advance) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			found_s1  <= found_d;
			occ_s1    <= occ_w[8:0];
			status_s1 <= status_d;
		end
		if (s1_advance) begin
			out_data_q   <= found_s1 ? rdata_w[31:0] : '0;
			out_found_q  <= found_s1;
			out_occ_q    <= occ_s1;
			out_status_q <= status_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_occ_q, out_data_q};
	assign m_tuser  = {out_status_q, out_found_q};

	`DEQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`DEQ_ASSERT_NEXT(a_full_push_drop, clk, arst_n,
		in_fire && is_full && (mode == MODE_PUSH_TOP || mode == MODE_PUSH_BOTTOM),
		$stable(count_q) && $stable(top_q))
	`DEQ_ASSERT_NEXT(a_clear_resets, clk, arst_n, in_fire && mode == MODE_CLEAR,
		count_q == '0 && top_q == '0 && !rev_q)
	`DEQ_ASSERT_NOW(a_stall_backpressure, clk, arst_n,
		s1_valid_q && out_valid_q && !m_tready, !s_tready)
	`DEQ_ASSERT_NOW(a_found_ok, clk, arst_n, out_valid_q && out_found_q,
		out_status_q == STATUS_OK)

endmodule

`default_nettype wire
